// ===== rtl/dspv_pkg.sv =====
package dspv_pkg;

   localparam int StrLen = 10;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;
   localparam logic [7:0] CharDash = 8'h2d;

   typedef logic [3:0] digit_type;

   // one finished string handed from the front to the calendar pipeline
   typedef struct packed {
      logic                 iso_ok;
      logic                 dmy_ok;
      digit_type [StrLen-1:0] digits;
   } job_type;

   // two decimal digits to a binary value
   function automatic logic [6:0] num2(input digit_type hi, input digit_type lo);
      num2 = 7'({3'b000, hi} * 7'd10) + 7'({3'b000, lo});
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      unique case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     month_len = 5'd30;
         4'd2:    month_len = leap ? 5'd29 : 5'd28;
         default: month_len = 5'd0;
      endcase
   endfunction

   // days in the months before month m
   function automatic logic [8:0] days_before(input logic [3:0] m);
      unique case (m)
         4'd2:    days_before = 9'd31;
         4'd3:    days_before = 9'd59;
         4'd4:    days_before = 9'd90;
         4'd5:    days_before = 9'd120;
         4'd6:    days_before = 9'd151;
         4'd7:    days_before = 9'd181;
         4'd8:    days_before = 9'd212;
         4'd9:    days_before = 9'd243;
         4'd10:   days_before = 9'd273;
         4'd11:   days_before = 9'd304;
         4'd12:   days_before = 9'd334;
         default: days_before = 9'd0;
      endcase
   endfunction

   // year given as century part and two low digits
   function automatic logic is_leap(input logic [6:0] yh, input logic [6:0] yl);
      is_leap = ((yl[1:0] == 2'b00) && (yl != 7'd0)) ||
                ((yl == 7'd0) && (yh[1:0] == 2'b00));
   endfunction

   function automatic logic day_ok(input logic [6:0] m, input logic [6:0] d,
                                   input logic leap);
      logic in_range;
      in_range = (m >= 7'd1) && (m <= 7'd12);
      day_ok = in_range && (d != 7'd0) &&
               (d <= {2'b00, month_len(m[3:0], leap)});
   endfunction

endpackage

// ===== rtl/date_string_parse_validate_weekday.sv =====
// Date string checker. Send the string one byte per request with req_last_char set on the
// final byte; that byte yields one response giving validity, the matched format (YYYY-MM-DD
// preferred over DD-MM-YYYY), year, month, day, zero-based day of year and weekday
// (0 = Sunday). Anything not exactly ten bytes in one of the two shapes, or with an
// impossible month or day, answers all zeros. One byte is taken every cycle while the queue
// is not full; the response for a string passes through the queue stage and then the
// three-stage calendar pipeline and its output register. The queue of QUEUE_DEPTH finished
// strings lets the byte side keep running while the response side stalls.
module date_string_parse_validate_weekday #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_date_valid,
   output logic        rsp_is_iso,
   output logic [13:0] rsp_year_value,
   output logic [3:0]  rsp_month_value,
   output logic [4:0]  rsp_day_value,
   output logic [8:0]  rsp_day_of_year,
   output logic [2:0]  rsp_weekday_code
);

   logic q_full, push, q_valid, q_pop;
   dspv_pkg::job_type push_job, pop_job;

   dspv_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_in   (req_char_in),
      .req_last_char (req_last_char),
      .q_full        (q_full),
      .push          (push),
      .job           (push_job)
   );

   dspv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .q_valid  (q_valid),
      .pop      (q_pop),
      .pop_job  (pop_job)
   );

   dspv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .job              (pop_job),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_date_valid   (rsp_date_valid),
      .rsp_is_iso       (rsp_is_iso),
      .rsp_year_value   (rsp_year_value),
      .rsp_month_value  (rsp_month_value),
      .rsp_day_value    (rsp_day_value),
      .rsp_day_of_year  (rsp_day_of_year),
      .rsp_weekday_code (rsp_weekday_code)
   );

endmodule

// ===== rtl/dspv_front.sv =====
module dspv_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_char_in,
   input  logic                 req_last_char,
   input  logic                 q_full,
   output logic                 push,
   output dspv_pkg::job_type    job
);

   localparam int StoreDepth = dspv_pkg::StrLen - 1;
   localparam logic [3:0] PosMax = 4'd15;

   logic [3:0] pos_ff, pos_in;
   logic iso_ok_ff, iso_ok_in;
   logic dmy_ok_ff, dmy_ok_in;
   dspv_pkg::digit_type digit_ff [StoreDepth];

   logic take, digit_char, is_dash, in_range, len_ok;
   logic iso_char_ok, dmy_char_ok, iso_ok_nx, dmy_ok_nx;
   dspv_pkg::digit_type cur_digit;

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      digit_char = (req_char_in >= dspv_pkg::CharZero) && (req_char_in <= dspv_pkg::CharNine);
      is_dash    = (req_char_in == dspv_pkg::CharDash);
      cur_digit  = digit_char ? req_char_in[3:0] : 4'd0;
      in_range   = pos_ff < 4'(dspv_pkg::StrLen);
      // dash positions: iso at 4 and 7, day-first at 2 and 5
      iso_char_ok = ((pos_ff == 4'd4) || (pos_ff == 4'd7)) ? is_dash : digit_char;
      dmy_char_ok = ((pos_ff == 4'd2) || (pos_ff == 4'd5)) ? is_dash : digit_char;
      iso_ok_nx = in_range && iso_ok_ff && iso_char_ok;
      dmy_ok_nx = in_range && dmy_ok_ff && dmy_char_ok;
      len_ok    = (pos_ff == 4'(dspv_pkg::StrLen - 1));

      pos_in    = pos_ff;
      iso_ok_in = iso_ok_ff;
      dmy_ok_in = dmy_ok_ff;
      if (take) begin
         if (req_last_char) begin
            pos_in    = 4'd0;
            iso_ok_in = 1'b1;
            dmy_ok_in = 1'b1;
         end else begin
            pos_in    = (pos_ff == PosMax) ? PosMax : pos_ff + 4'd1;
            iso_ok_in = iso_ok_nx;
            dmy_ok_in = dmy_ok_nx;
         end
      end

      push       = take && req_last_char;
      job.iso_ok = iso_ok_nx && len_ok;
      job.dmy_ok = dmy_ok_nx && len_ok;
      for (int i = 0; i < StoreDepth; i++) begin
         job.digits[i] = digit_ff[i];
      end
      // final digit goes straight through
      job.digits[dspv_pkg::StrLen-1] = cur_digit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 4'd0;
         iso_ok_ff <= 1'b1;
         dmy_ok_ff <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         iso_ok_ff <= iso_ok_in;
         dmy_ok_ff <= dmy_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && (pos_ff < 4'(StoreDepth))) begin
         digit_ff[pos_ff] <= cur_digit;
      end
   end

endmodule

// ===== rtl/dspv_queue.sv =====
module dspv_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dspv_pkg::job_type push_job,
   output logic              full,
   output logic              q_valid,
   input  logic              pop,
   output dspv_pkg::job_type pop_job
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

   dspv_pkg::job_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/dspv_back.sv =====
module dspv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  dspv_pkg::job_type job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_date_valid,
   output logic              rsp_is_iso,
   output logic [13:0]       rsp_year_value,
   output logic [3:0]        rsp_month_value,
   output logic [4:0]        rsp_day_value,
   output logic [8:0]        rsp_day_of_year,
   output logic [2:0]        rsp_weekday_code
);

   // floor(x / 7) == (x * Recip7) >> 17 for every x below 2**14
   localparam logic [28:0] Recip7 = 29'd18725;

   logic adv;

   // stage 1: pick the format and check the fields
   logic s1_busy_ff, s1_ok_ff, s1_iso_ff, s1_leap_ff;
   logic [6:0] s1_yh_ff, s1_yl_ff, s1_m_ff, s1_d_ff;
   logic s1_ok_in, s1_iso_in, s1_leap_in;
   logic [6:0] s1_yh_in, s1_yl_in, s1_m_in, s1_d_in;

   // stage 2: year, day of year and the year's day code sum
   logic s2_busy_ff, s2_ok_ff, s2_iso_ff;
   logic [13:0] s2_year_ff, s2_csum_ff;
   logic [3:0] s2_m_ff;
   logic [4:0] s2_d_ff;
   logic [8:0] s2_doy_ff;
   logic [13:0] s2_year_in, s2_csum_in;
   logic [8:0] s2_doy_in;

   // stage 3: total for the weekday
   logic s3_busy_ff, s3_ok_ff, s3_iso_ff;
   logic [13:0] s3_year_ff, s3_tot_ff;
   logic [3:0] s3_m_ff;
   logic [4:0] s3_d_ff;
   logic [8:0] s3_doy_ff;

   // output register
   logic rsp_valid_ff, ok_ff, iso_ff;
   logic [13:0] year_ff;
   logic [3:0] month_ff;
   logic [4:0] day_ff;
   logic [8:0] doy_ff;
   logic [2:0] wd_ff;
   logic [2:0] wd_in;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   always_comb begin
      logic [6:0] iy_h, iy_l, im, id, dy_h, dy_l, dm, dd;
      logic i_leap, d_leap, i_good, d_good;
      iy_h = dspv_pkg::num2(job.digits[0], job.digits[1]);
      iy_l = dspv_pkg::num2(job.digits[2], job.digits[3]);
      im   = dspv_pkg::num2(job.digits[5], job.digits[6]);
      id   = dspv_pkg::num2(job.digits[8], job.digits[9]);
      dy_h = dspv_pkg::num2(job.digits[6], job.digits[7]);
      dy_l = dspv_pkg::num2(job.digits[8], job.digits[9]);
      dm   = dspv_pkg::num2(job.digits[3], job.digits[4]);
      dd   = dspv_pkg::num2(job.digits[0], job.digits[1]);
      i_leap = dspv_pkg::is_leap(iy_h, iy_l);
      d_leap = dspv_pkg::is_leap(dy_h, dy_l);
      i_good = job.iso_ok && dspv_pkg::day_ok(im, id, i_leap);
      d_good = job.dmy_ok && dspv_pkg::day_ok(dm, dd, d_leap);
      s1_ok_in   = i_good || d_good;
      s1_iso_in  = i_good;
      s1_yh_in   = i_good ? iy_h : dy_h;
      s1_yl_in   = i_good ? iy_l : dy_l;
      s1_m_in    = i_good ? im : dm;
      s1_d_in    = i_good ? id : dd;
      s1_leap_in = i_good ? i_leap : d_leap;
   end

   always_comb begin
      logic [6:0] cent, rest;
      logic past_feb;
      s2_year_in = 14'(s1_yh_ff * 14'd100) + 14'(s1_yl_ff);
      // y - 1 split as 100 * cent + rest
      cent = (s1_yl_ff == 7'd0) ? s1_yh_ff - 7'd1 : s1_yh_ff;
      rest = (s1_yl_ff == 7'd0) ? 7'd99 : s1_yl_ff - 7'd1;
      if ((s1_yh_ff == 7'd0) && (s1_yl_ff == 7'd0)) begin
         s2_csum_in = 14'd0;
      end else begin
         s2_csum_in = s2_year_in + 14'(cent * 14'd24) + 14'(rest >> 2) + 14'(cent >> 2);
      end
      past_feb  = (s1_m_ff > 7'd2) && s1_leap_ff;
      s2_doy_in = 9'(s1_d_ff) - 9'd1 + dspv_pkg::days_before(s1_m_ff[3:0])
                  + 9'(past_feb);
   end

   always_comb begin
      logic [28:0] prod;
      logic [13:0] quo, rem;
      prod  = 29'(s3_tot_ff) * Recip7;
      quo   = 14'(prod[28:17]);
      rem   = s3_tot_ff - 14'(quo * 14'd7);
      wd_in = rem[2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_busy_ff   <= 1'b0;
         s2_busy_ff   <= 1'b0;
         s3_busy_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_busy_ff   <= q_valid;
         s2_busy_ff   <= s1_busy_ff;
         s3_busy_ff   <= s2_busy_ff;
         rsp_valid_ff <= s3_busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ok_ff   <= s1_ok_in;
         s1_iso_ff  <= s1_iso_in;
         s1_yh_ff   <= s1_yh_in;
         s1_yl_ff   <= s1_yl_in;
         s1_m_ff    <= s1_m_in;
         s1_d_ff    <= s1_d_in;
         s1_leap_ff <= s1_leap_in;

         s2_ok_ff   <= s1_ok_ff;
         s2_iso_ff  <= s1_iso_ff;
         s2_year_ff <= s2_year_in;
         s2_csum_ff <= s2_csum_in;
         s2_m_ff    <= s1_m_ff[3:0];
         s2_d_ff    <= s1_d_ff[4:0];
         s2_doy_ff  <= s2_doy_in;

         s3_ok_ff   <= s2_ok_ff;
         s3_iso_ff  <= s2_iso_ff;
         s3_year_ff <= s2_year_ff;
         s3_tot_ff  <= s2_csum_ff + 14'(s2_doy_ff);
         s3_m_ff    <= s2_m_ff;
         s3_d_ff    <= s2_d_ff;
         s3_doy_ff  <= s2_doy_ff;

         // invalid dates come out as all zeros
         ok_ff    <= s3_ok_ff;
         iso_ff   <= s3_ok_ff && s3_iso_ff;
         year_ff  <= s3_ok_ff ? s3_year_ff : 14'd0;
         month_ff <= s3_ok_ff ? s3_m_ff : 4'd0;
         day_ff   <= s3_ok_ff ? s3_d_ff : 5'd0;
         doy_ff   <= s3_ok_ff ? s3_doy_ff : 9'd0;
         wd_ff    <= s3_ok_ff ? wd_in : 3'd0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_date_valid   = ok_ff;
   assign rsp_is_iso       = iso_ff;
   assign rsp_year_value   = year_ff;
   assign rsp_month_value  = month_ff;
   assign rsp_day_value    = day_ff;
   assign rsp_day_of_year  = doy_ff;
   assign rsp_weekday_code = wd_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_req_type;

   typedef struct packed {
      logic        date_valid;
      logic        is_iso;
      logic [13:0] year_value;
      logic [3:0]  month_value;
      logic [4:0]  day_value;
      logic [8:0]  day_of_year;
      logic [2:0]  weekday_code;
   } date_rsp_type;

   localparam int IdleLimit = 2000;
   localparam int HoldCycles = 400;
   localparam int HoldAfter = 30;
   localparam logic [3:0] PosSaturate = 4'd15;

   logic        clock;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = '0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_date_valid;
   logic        rsp_is_iso;
   logic [13:0] rsp_year_value;
   logic [3:0]  rsp_month_value;
   logic [4:0]  rsp_day_value;
   logic [8:0]  rsp_day_of_year;
   logic [2:0]  rsp_weekday_code;

   char_req_type pending_chars[$];
   date_rsp_type expected_dates[$];
   logic [7:0]  text_q[$];

   // parser state mirrored from the block
   logic [3:0]  char_count = '0;
   logic        iso_shape = 1'b1;
   logic        dmy_shape = 1'b1;
   logic [3:0]  digit_vals[10] = '{default: '0};

   int          errors = 0;
   int          results_seen = 0;
   bit          req_taken = 1'b0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          stall_mode = 0;
   int          mode_left = 0;
   int          idle_cycles = 0;
   int unsigned edge_years[8] = '{0, 1, 4, 100, 400, 1900, 2000, 9999};

   date_string_parse_validate_weekday dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_in      (req_char_in),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_date_valid   (rsp_date_valid),
      .rsp_is_iso       (rsp_is_iso),
      .rsp_year_value   (rsp_year_value),
      .rsp_month_value  (rsp_month_value),
      .rsp_day_value    (rsp_day_value),
      .rsp_day_of_year  (rsp_day_of_year),
      .rsp_weekday_code (rsp_weekday_code)
   );

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic int unsigned field_value(input int start, input int len);
      int unsigned v;
      v = 0;
      for (int i = 0; i < len; i++) v = v * 10 + digit_vals[(start + i) % dspv_pkg::StrLen];
      return v;
   endfunction

   // advance the parser by one accepted request, queue the response on the final byte
   task automatic parse_char(input logic [7:0] ch, input logic last);
      date_rsp_type r;
      int unsigned y, m, d, doy, code;
      int          fmt;
      bit          digit_char, is_dash;
      digit_char = (ch >= dspv_pkg::CharZero) && (ch <= dspv_pkg::CharNine);
      is_dash = (ch == dspv_pkg::CharDash);
      if (char_count < dspv_pkg::StrLen) begin
         if ((char_count == 4 || char_count == 7) ? !is_dash : !digit_char) iso_shape = 1'b0;
         if ((char_count == 2 || char_count == 5) ? !is_dash : !digit_char) dmy_shape = 1'b0;
         digit_vals[char_count] = digit_char ? 4'(ch - dspv_pkg::CharZero) : 4'd0;
      end else begin
         iso_shape = 1'b0;
         dmy_shape = 1'b0;
      end
      if (char_count != PosSaturate) char_count = char_count + 4'd1;
      if (last) begin
         r = '0;
         if (char_count == dspv_pkg::StrLen) begin
            // iso shape wins when both would decode
            for (fmt = 1; fmt >= 0; fmt--) begin
               if (!r.date_valid && ((fmt == 1) ? iso_shape : dmy_shape)) begin
                  y = field_value((fmt == 1) ? 0 : 6, 4);
                  m = field_value((fmt == 1) ? 5 : 3, 2);
                  d = field_value((fmt == 1) ? 8 : 0, 2);
                  if (d >= 1 && d <= days_in_month(m, y)) begin
                     r.date_valid = 1'b1;
                     r.is_iso = (fmt == 1);
                     r.year_value = 14'(y);
                     r.month_value = 4'(m);
                     r.day_value = 5'(d);
                  end
               end
            end
         end
         if (r.date_valid) begin
            y = r.year_value;
            m = r.month_value;
            doy = r.day_value - 1;
            for (int k = 1; k < m; k++) doy += days_in_month(k, y);
            code = (y == 0) ? 0 : (y + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400) % 7;
            r.day_of_year = 9'(doy);
            r.weekday_code = 3'((code + doy) % 7);
         end
         expected_dates.push_back(r);
         char_count = '0;
         iso_shape = 1'b1;
         dmy_shape = 1'b1;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic load_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic queue_text();
      foreach (text_q[i]) pending_chars.push_back('{text_q[i], i == text_q.size() - 1});
   endtask

   function automatic logic [7:0] mixed_char();
      case ($urandom_range(0, 2))
         0:       return dspv_pkg::CharZero + 8'($urandom_range(0, 9));
         1:       return dspv_pkg::CharDash;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request side: take note of accepted requests
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         parse_char(req_char_in, req_last_char);
         req_taken = 1'b1;
      end
   end

   // request side: bursts with random gaps
   always @(negedge clock) begin
      char_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until accepted
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
         item = pending_chars.pop_front();
         req_valid <= 1'b1;
         req_char_in <= item.ch;
         req_last_char <= item.last;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
      end else begin
         req_valid <= 1'b0;
      end
      req_taken = 1'b0;
   end

   // response side: stall pattern plus one long hold-off
   always @(negedge clock) begin
      bit ready_next;
      if (reset) begin
         ready_next = 1'b0;
      end else begin
         if (!hold_done && results_seen >= HoldAfter) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
         end
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (stall_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = $urandom_range(0, 1);
               2:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = mode_left[2];
            endcase
         end
      end
      rsp_ready <= ready_next;
   end

   always @(posedge clock) begin
      date_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_dates.size() == 0) begin
            $error("response with no request string pending");
            errors++;
         end else begin
            want = expected_dates.pop_front();
            check_field("date_valid", want.date_valid, rsp_date_valid);
            check_field("is_iso", want.is_iso, rsp_is_iso);
            check_field("year_value", want.year_value, rsp_year_value);
            check_field("month_value", want.month_value, rsp_month_value);
            check_field("day_value", want.day_value, rsp_day_value);
            check_field("day_of_year", want.day_of_year, rsp_day_of_year);
            check_field("weekday_code", want.weekday_code, rsp_weekday_code);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("[date_string_parse_validate_weekday] ERROR");
            $finish;
         end
      end
   end

   initial begin
      int unsigned y, m, d, len;
      int          kind, random_chars;
      bit          iso_fmt;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // year zero leap day, largest dmy date, one-byte strings with extreme bytes
      load_text("0000-02-29");
      queue_text();
      load_text("31-12-9999");
      queue_text();
      text_q = '{8'hff};
      queue_text();
      text_q = '{8'h00};
      queue_text();

      // let everything drain before the random part
      wait (pending_chars.size() == 0 && !req_valid && expected_dates.size() == 0);

      random_chars = 0;
      while (random_chars < 1250) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            y = ($urandom_range(0, 4) == 0) ? edge_years[$urandom_range(0, 7)]
                                            : $urandom_range(0, 9999);
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
            d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
            if ($urandom_range(0, 7) == 0) begin
               m = 2;
               d = 29;
            end
            iso_fmt = $urandom_range(0, 1);
            load_text(iso_fmt ? $sformatf("%04d-%02d-%02d", y, m, d)
                              : $sformatf("%02d-%02d-%04d", d, m, y));
            // some well-formed strings get one byte damaged
            if (kind >= 55) text_q[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
         end else if (kind < 85) begin
            len = $urandom_range(1, 24);
            if (len == 10) len = 11;
            text_q.delete();
            repeat (len) text_q.push_back(mixed_char());
         end else begin
            text_q.delete();
            repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
         end
         random_chars += text_q.size();
         queue_text();
      end

      wait (pending_chars.size() == 0 && !req_valid && expected_dates.size() == 0);
      repeat (12) @(posedge clock);
      if (errors == 0) begin
         $display("[date_string_parse_validate_weekday] OK");
      end else begin
         $display("[date_string_parse_validate_weekday] ERROR");
      end
      $finish;
   end

endmodule
